>>> rtl/oaid_pkg.sv
package oaid_pkg;

  localparam logic [1:0] REQ_INSERT_AT   = 2'd0;
  localparam logic [1:0] REQ_APPEND      = 2'd1;
  localparam logic [1:0] REQ_DELETE_AT   = 2'd2;
  localparam logic [1:0] REQ_DELETE_LAST = 2'd3;

  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_BAD  = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE
  } op_e;

  typedef struct packed {
    logic       load;
    op_e        op;
    logic [1:0] status;
  } dp_cmd_t;

endpackage

>>> rtl/oaid_if.sv
interface oaid_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [4:0]         position;
  logic signed [31:0] new_value;

  modport source (output valid, output req_type, output position, output new_value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input new_value,
                  output ready);
endinterface

interface oaid_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] removed_value;
  logic [1:0]         status;
  logic [4:0]         length_now;

  modport source (output valid, output removed_value, output status, output length_now,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input length_now,
                  output ready);
endinterface

>>> rtl/oaid_ctrl.sv
module oaid_ctrl #(
  parameter int CAPACITY = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     req_type_i,
  input  logic [4:0]                     position_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  input  logic [$clog2(CAPACITY+1)-1:0]  count_i,
  output oaid_pkg::dp_cmd_t              cmd_o,
  output logic [$clog2(CAPACITY)-1:0]    idx_o
);
  import oaid_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = (CW > 5) ? CW : 5;

  localparam logic S_EMPTY = 1'b0;
  localparam logic S_HOLD  = 1'b1;

  logic          state_q, state_d;
  logic          accept;
  logic [PW-1:0] pos_ext, cnt_ext;
  logic          full, empty;

  assign in_ready_o  = (state_q == S_EMPTY) || out_ready_i;
  assign out_valid_o = (state_q == S_HOLD);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = S_HOLD;
    end else if (out_ready_i) begin
      state_d = S_EMPTY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  assign pos_ext = PW'(position_i);
  assign cnt_ext = PW'(count_i);
  assign full    = (count_i == CW'(CAPACITY));
  assign empty   = (count_i == '0);

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.op     = OP_NONE;
    cmd_o.status = STS_OK;
    idx_o        = '0;
    unique case (req_type_i)
      REQ_INSERT_AT: begin
        if (pos_ext > cnt_ext) begin
          cmd_o.status = STS_BAD;
        end else if (full) begin
          cmd_o.status = STS_FULL;
        end else begin
          cmd_o.op = OP_INSERT;
          idx_o    = IW'(position_i);
        end
      end
      REQ_APPEND: begin
        if (full) begin
          cmd_o.status = STS_FULL;
        end else begin
          cmd_o.op = OP_INSERT;
          idx_o    = IW'(count_i);
        end
      end
      REQ_DELETE_AT: begin
        if (pos_ext >= cnt_ext) begin
          cmd_o.status = STS_BAD;
        end else begin
          cmd_o.op = OP_DELETE;
          idx_o    = IW'(position_i);
        end
      end
      REQ_DELETE_LAST: begin
        if (empty) begin
          cmd_o.status = STS_BAD;
        end else begin
          cmd_o.op = OP_DELETE;
          idx_o    = IW'(count_i - 1'b1);
        end
      end
      default: begin
        cmd_o.status = STS_BAD;
      end
    endcase
    if (!accept) begin
      cmd_o.op = OP_NONE;
    end
  end

endmodule

>>> rtl/oaid_dp.sv
module oaid_dp #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  oaid_pkg::dp_cmd_t             cmd_i,
  input  logic [$clog2(CAPACITY)-1:0]   idx_i,
  input  logic signed [31:0]            new_value_i,
  output logic [$clog2(CAPACITY+1)-1:0] count_o,
  output logic signed [31:0]            removed_value_o,
  output logic [1:0]                    status_o,
  output logic [4:0]                    length_now_o
);
  import oaid_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic signed [WORD_BITS-1:0] ent_q    [CAPACITY];
  logic signed [WORD_BITS-1:0] ent_d    [CAPACITY];
  logic signed [WORD_BITS-1:0] prev_w   [CAPACITY];
  logic signed [WORD_BITS-1:0] next_w   [CAPACITY];
  logic signed [WORD_BITS-1:0] word;
  logic [CW-1:0]               count_q, count_d;
  logic signed [31:0]          removed_q, removed_d;
  logic [1:0]                  status_q;
  logic [4:0]                  length_q;

  assign word = WORD_BITS'(new_value_i);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [IW-1:0] G = IW'(g);

    if (g == 0) begin : g_first
      assign prev_w[g] = ent_q[g];
    end else begin : g_mid_prev
      assign prev_w[g] = ent_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_w[g] = ent_q[g];
    end else begin : g_mid_next
      assign next_w[g] = ent_q[g+1];
    end

    always_comb begin
      ent_d[g] = ent_q[g];
      unique case (cmd_i.op)
        OP_INSERT: begin
          if (G > idx_i) begin
            ent_d[g] = prev_w[g];
          end else if (G == idx_i) begin
            ent_d[g] = word;
          end
        end
        OP_DELETE: begin
          if (G >= idx_i) begin
            ent_d[g] = next_w[g];
          end
        end
        OP_NONE: ;
        default: ;
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.op != OP_NONE) begin
        ent_q[g] <= ent_d[g];
      end
    end
  end

  always_comb begin
    count_d   = count_q;
    removed_d = '0;
    unique case (cmd_i.op)
      OP_INSERT: count_d = count_q + 1'b1;
      OP_DELETE: begin
        count_d   = count_q - 1'b1;
        removed_d = 32'(ent_q[idx_i]);
      end
      OP_NONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      removed_q <= removed_d;
      status_q  <= cmd_i.status;
      length_q  <= 5'(count_d);
    end
  end

  assign count_o         = count_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign length_now_o    = length_q;

endmodule

>>> rtl/ordered_array_insert_delete.sv
// Ordered word list with insert-at, append, delete-at and delete-last.
// The result is registered and valid in the cycle after a request word is accepted.
// Throughput: 1 word per cycle while results are taken; the whole cell row
// shifts together, so each request finishes in its accept cycle.
// Reset: count and result valid clear at once; stored words are not cleared.
module ordered_array_insert_delete #(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  oaid_req_if.sink   req_i,
  oaid_rsp_if.source rsp_o
);
  import oaid_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  dp_cmd_t       cmd;
  logic [IW-1:0] idx;
  logic [CW-1:0] count;

  oaid_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .req_type_i (req_i.req_type),
    .position_i (req_i.position),
    .out_valid_o(rsp_o.valid),
    .out_ready_i(rsp_o.ready),
    .count_i    (count),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  oaid_dp #(
    .CAPACITY (CAPACITY),
    .WORD_BITS(WORD_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .idx_i          (idx),
    .new_value_i    (req_i.new_value),
    .count_o        (count),
    .removed_value_o(rsp_o.removed_value),
    .status_o       (rsp_o.status),
    .length_now_o   (rsp_o.length_now)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(CAPACITY))
    else $error("count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == OP_INSERT |=> count == CW'($past(count) + 1'b1))
    else $error("insert did not grow count");

  a_refused_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load && cmd.op == OP_NONE) |=> $stable(count))
    else $error("refused request changed count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == STS_FULL) |-> count == CW'(CAPACITY))
    else $error("full status with room left");

endmodule
